@@ design/ws2812_pwm_serializer_core_macros.svh @@
// ---------------------------------------------------------------------------
// ws2812 pwm serializer assertion macros
// property wrappers clocked on aclk and disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef WS2812_PWM_SERIALIZER_CORE_MACROS_SVH
`define WS2812_PWM_SERIALIZER_CORE_MACROS_SVH

// same-cycle implication
`define WPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wps assertion failed");

// next-cycle implication
`define WPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wps assertion failed");

`endif

@@ design/wps_pkg.sv @@
// ---------------------------------------------------------------------------
// wps_pkg
// shared constants, types and helpers of the ws2812 pwm serializer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wps_pkg;

    localparam int MAX_LEDS     = 64;
    localparam int RESET_SLOTS  = 40;
    localparam int BITS_PER_LED = 24;
    localparam int RGB_W        = 24;
    localparam int LED_W        = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W        = $clog2(MAX_LEDS + 1);
    localparam int SLOT_W       = $clog2(RESET_SLOTS);
    localparam int BIT_W        = 5;
    localparam int ACT_W        = 7;
    localparam int PER_W        = 16;
    localparam int ADDR_W       = 3;

    localparam logic [7:0]      LEVEL_ON     = 8'd254;
    localparam logic [15:0]     RECIP3       = 16'hAAAB;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(RESET_SLOTS - 1);
    localparam logic [BIT_W-1:0]  BIT_LAST   = BIT_W'(BITS_PER_LED - 1);
    localparam logic [CNT_W-1:0]  LED_MAX    = CNT_W'(MAX_LEDS);

    localparam logic REG_PWM_PERIOD  = 1'b0;
    localparam logic REG_ACTIVE_LEDS = 1'b1;

    localparam logic [2:0] PAL_BLACK  = 3'd0;
    localparam logic [2:0] PAL_RED    = 3'd1;
    localparam logic [2:0] PAL_GREEN  = 3'd2;
    localparam logic [2:0] PAL_BLUE   = 3'd3;
    localparam logic [2:0] PAL_YELLOW = 3'd4;
    localparam logic [2:0] PAL_PURPLE = 3'd5;
    localparam logic [2:0] PAL_CYAN   = 3'd6;
    localparam logic [2:0] PAL_WHITE  = 3'd7;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_PALETTE = 2'd1,
        MODE_SET_ALL = 2'd2,
        MODE_START   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_LEAD = 2'd1,
        PHASE_DATA = 2'd2,
        PHASE_TAIL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        DUTY_ZERO  = 2'd0,
        DUTY_THIRD = 2'd1,
        DUTY_DATA  = 2'd2
    } duty_sel_t;

    typedef struct packed {
        duty_sel_t        sel;
        logic [BIT_W-1:0] bit_pos;
        logic             busy;
    } slot_t;

    typedef struct packed {
        logic             pal_we;
        logic [LED_W-1:0] pal_idx;
        logic [RGB_W-1:0] pal_rgb;
        logic             set_we;
        logic [RGB_W-1:0] set_rgb;
        logic [CNT_W-1:0] set_n;
    } store_cmd_t;

    function automatic logic [RGB_W-1:0] palette(input logic [2:0] code);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = 8'd0;
        g = 8'd0;
        b = 8'd0;
        case (code)
            PAL_RED: begin
                r = LEVEL_ON;
            end
            PAL_GREEN: begin
                g = LEVEL_ON;
            end
            PAL_BLUE: begin
                b = LEVEL_ON;
            end
            PAL_YELLOW: begin
                r = LEVEL_ON;
                g = LEVEL_ON;
            end
            PAL_PURPLE: begin
                r = LEVEL_ON;
                b = LEVEL_ON;
            end
            PAL_CYAN: begin
                g = LEVEL_ON;
                b = LEVEL_ON;
            end
            PAL_WHITE: begin
                r = LEVEL_ON;
                g = LEVEL_ON;
                b = LEVEL_ON;
            end
            default: begin
                r = 8'd0;
            end
        endcase
        return {r, g, b};
    endfunction

    // wire order is green, red, blue, msb first
    function automatic logic grb_bit(input logic [RGB_W-1:0] rgb,
                                     input logic [BIT_W-1:0] pos);
        logic [RGB_W-1:0] grb;
        logic [BIT_W-1:0] sel;
        grb = {rgb[15:8], rgb[23:16], rgb[7:0]};
        sel = BIT_LAST - pos;
        return grb[sel];
    endfunction

endpackage

@@ design/wps_ram.sv @@
// ---------------------------------------------------------------------------
// wps_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/wps_store.sv @@
// ---------------------------------------------------------------------------
// wps_store
// led color store: ram plus a background fill sweep for set-all requests
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ws2812_pwm_serializer_core_macros.svh"

module wps_store
    import wps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  store_cmd_t       cmd,
    input  logic             rd_en,
    input  logic [LED_W-1:0] rd_idx,
    output logic [RGB_W-1:0] rd_rgb,
    output logic             sweeping
);

    logic                sweep_reg;
    logic [LED_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]    fill_n_reg;
    logic [RGB_W-1:0]    fill_rgb_reg;
    logic [MAX_LEDS-1:0] touched_reg;
    logic                pend_reg;

    logic                step;
    logic                sweep_we;
    logic                ram_we;
    logic [LED_W-1:0]    ram_waddr;
    logic [RGB_W-1:0]    ram_wdata;
    logic [RGB_W-1:0]    ram_rdata;
    logic                pend_next;
    logic [CNT_W-1:0]    ptr_inc;

    // reset starts a sweep of zeros over the whole store
    assign step      = sweep_reg && !cmd.pal_we && !cmd.set_we;
    assign sweep_we  = step && !touched_reg[ptr_reg];
    assign ram_we    = cmd.pal_we || sweep_we;
    assign ram_waddr = cmd.pal_we ? cmd.pal_idx : ptr_reg;
    assign ram_wdata = cmd.pal_we ? cmd.pal_rgb : fill_rgb_reg;
    assign ptr_inc   = CNT_W'({1'b0, ptr_reg}) + CNT_W'(1);

    assign pend_next = sweep_reg
                    && (rd_idx >= ptr_reg)
                    && (CNT_W'({1'b0, rd_idx}) < fill_n_reg)
                    && !touched_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg    <= 1'b1;
            ptr_reg      <= '0;
            fill_n_reg   <= LED_MAX;
            fill_rgb_reg <= '0;
            touched_reg  <= '0;
            pend_reg     <= 1'b0;
        end else begin
            if (cmd.set_we) begin
                sweep_reg    <= 1'b1;
                ptr_reg      <= '0;
                fill_n_reg   <= cmd.set_n;
                fill_rgb_reg <= cmd.set_rgb;
                touched_reg  <= '0;
            end else begin
                if (cmd.pal_we) begin
                    touched_reg[cmd.pal_idx] <= 1'b1;
                end
                if (step) begin
                    if (ptr_inc >= fill_n_reg) begin
                        sweep_reg <= 1'b0;
                    end else begin
                        ptr_reg <= ptr_inc[LED_W-1:0];
                    end
                end
            end
            if (rd_en) begin
                pend_reg <= pend_next;
            end
        end
    end

    wps_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_LEDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    assign rd_rgb   = pend_reg ? fill_rgb_reg : ram_rdata;
    assign sweeping = sweep_reg;

    `WPS_ASSERT_NEXT(a_fill_starts, cmd.set_we, sweep_reg && (ptr_reg == '0))
    `WPS_ASSERT_NOW(a_ptr_in_fill, sweep_reg, CNT_W'({1'b0, ptr_reg}) < fill_n_reg)

endmodule

@@ design/wps_frame.sv @@
// ---------------------------------------------------------------------------
// wps_frame
// frame sequencer: lead reset slots, 24 data slots per led, tail reset slots
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ws2812_pwm_serializer_core_macros.svh"

module wps_frame
    import wps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tick,
    input  logic             start,
    input  logic [CNT_W-1:0] led_n,
    output slot_t            slot,
    output logic             rd_en,
    output logic [LED_W-1:0] rd_idx,
    output logic             idle
);

    phase_t            phase_reg,  phase_next;
    logic [SLOT_W-1:0] slot_reg,   slot_next;
    logic [CNT_W-1:0]  led_reg,    led_next;
    logic [BIT_W-1:0]  bit_reg,    bit_next;
    logic [CNT_W-1:0]  led_inc;

    assign led_inc = led_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_IDLE;
            slot_reg  <= '0;
            led_reg   <= '0;
            bit_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            led_reg   <= led_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        led_next     = led_reg;
        bit_next     = bit_reg;
        slot.sel     = DUTY_ZERO;
        slot.bit_pos = bit_reg;
        slot.busy    = (phase_reg != PHASE_IDLE);
        rd_en        = 1'b0;
        case (phase_reg)
            PHASE_IDLE: begin
                if (start) begin
                    phase_next = PHASE_LEAD;
                    slot_next  = '0;
                    led_next   = '0;
                    bit_next   = '0;
                end
            end
            PHASE_LEAD: begin
                slot.sel = (slot_reg == '0) ? DUTY_THIRD : DUTY_ZERO;
                if (tick) begin
                    if (slot_reg == SLOT_LAST) begin
                        phase_next = PHASE_DATA;
                        slot_next  = '0;
                        led_next   = '0;
                        bit_next   = '0;
                    end else begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end
            PHASE_DATA: begin
                slot.sel = DUTY_DATA;
                rd_en    = tick;
                if (tick) begin
                    if (bit_reg == BIT_LAST) begin
                        bit_next = '0;
                        led_next = led_inc;
                        if (led_inc >= led_n) begin
                            phase_next = PHASE_TAIL;
                            slot_next  = '0;
                        end
                    end else begin
                        bit_next = bit_reg + BIT_W'(1);
                    end
                end
            end
            PHASE_TAIL: begin
                if (tick) begin
                    if (slot_reg == SLOT_LAST) begin
                        phase_next = PHASE_IDLE;
                        slot_next  = '0;
                        led_next   = '0;
                        bit_next   = '0;
                    end else begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end
            default: begin
                phase_next = PHASE_IDLE;
            end
        endcase
    end

    assign rd_idx = led_reg[LED_W-1:0];
    assign idle   = (phase_reg == PHASE_IDLE);

    `WPS_ASSERT_NOW(a_idle_clean, phase_reg == PHASE_IDLE,
        (slot_reg == '0) && (led_reg == '0) && (bit_reg == '0))
    `WPS_ASSERT_NOW(a_data_bounds, phase_reg == PHASE_DATA,
        (bit_reg <= BIT_LAST) && (led_reg < LED_MAX))

endmodule

@@ design/ws2812_pwm_serializer_core.sv @@
// ---------------------------------------------------------------------------
// ws2812_pwm_serializer_core
// ws2812 led strip serializer producing one pwm compare value per bit slot
// ---------------------------------------------------------------------------
// Every request yields one result through stage 1 and the output register; a
// request can be taken every cycle unless the output stalls. The color store is
// a 64 x 24 ram with one write port: a set-all request is written into it by a
// background fill of one led per cycle (palette writes take the port first),
// while reads of not yet filled leds return the new color at once. A set-all
// request that arrives while a fill is still running waits until it ends. After
// reset the same fill clears the store; other requests are taken during it.
// Both pwm duties are derived from pwm_period when it is written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ws2812_pwm_serializer_core_macros.svh"

module ws2812_pwm_serializer_core
    import wps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // apb
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // requests
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,  // led_index, color_code, red, green, blue, zero pad
    input  logic [1:0]        s_tuser,  // mode
    // results
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata   // duty, line_enabled, busy_res, accepted, zero pad
);

    logic [PER_W-1:0] period_reg;
    logic [PER_W-1:0] third_reg;
    logic [PER_W-1:0] two_third_reg;
    logic [ACT_W-1:0] active_reg;

    logic [31:0]      recip_prod;
    logic [PER_W-1:0] third_calc;
    logic [1:0]       three_t_lo;
    logic [1:0]       rem;
    logic             cfg_we;

    mode_t            mode;
    logic [LED_W-1:0] led_index;
    logic [2:0]       color_code;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [CNT_W-1:0] led_n;

    logic             accept;
    logic             out_load;
    logic             adv;
    logic             sweeping;
    logic             idx_ok;
    logic             accepted_now;
    logic             busy_now;
    store_cmd_t       cmd;

    slot_t            slot;
    logic             rd_en;
    logic [LED_W-1:0] rd_idx;
    logic             frame_idle;
    logic [RGB_W-1:0] rd_rgb;

    logic             st1_valid_reg;
    duty_sel_t        st1_sel_reg;
    logic [BIT_W-1:0] st1_bit_reg;
    logic             st1_busy_reg;
    logic             st1_acc_reg;
    logic [PER_W-1:0] duty_calc;

    logic             m_valid_reg;
    logic [PER_W-1:0] m_duty_reg;
    logic             m_busy_reg;
    logic             m_acc_reg;

    // configuration
    assign pready     = 1'b1;
    assign cfg_we     = psel && penable && pwrite && pready;
    assign recip_prod = {16'd0, pwdata[15:0]} * {16'd0, RECIP3};
    assign third_calc = {1'b0, recip_prod[31:17]};
    assign three_t_lo = 2'(third_calc[1:0] + {third_calc[0], 1'b0});
    assign rem        = 2'(pwdata[1:0] - three_t_lo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= PER_W'(105);
            third_reg     <= PER_W'(35);
            two_third_reg <= PER_W'(70);
            active_reg    <= ACT_W'(64);
        end else if (cfg_we) begin
            case (paddr[2])
                REG_PWM_PERIOD: begin
                    period_reg    <= pwdata[PER_W-1:0];
                    third_reg     <= third_calc;
                    two_third_reg <= {third_calc[PER_W-2:0], 1'b0} + PER_W'(rem == 2'd2);
                end
                REG_ACTIVE_LEDS: begin
                    active_reg <= pwdata[ACT_W-1:0];
                end
                default: begin
                    active_reg <= active_reg;
                end
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_ACTIVE_LEDS) ? {25'd0, active_reg}
                                                  : {16'd0, period_reg};

    always_comb begin
        if (active_reg == '0) begin
            led_n = CNT_W'(1);
        end else if (CNT_W'(active_reg) > LED_MAX) begin
            led_n = LED_MAX;
        end else begin
            led_n = CNT_W'(active_reg);
        end
    end

    // request decode
    assign mode       = mode_t'(s_tuser);
    assign led_index  = s_tdata[LED_W-1:0];
    assign color_code = s_tdata[8:6];
    assign red        = s_tdata[16:9];
    assign green      = s_tdata[24:17];
    assign blue       = s_tdata[32:25];

    assign out_load = !m_valid_reg || m_tready;
    assign adv      = !st1_valid_reg || out_load;
    assign s_tready = adv && !(sweeping && (mode == MODE_SET_ALL));
    assign accept   = s_tvalid && s_tready;
    assign idx_ok   = CNT_W'({1'b0, led_index}) < led_n;

    always_comb begin
        accepted_now = 1'b0;
        busy_now     = !frame_idle;
        case (mode)
            MODE_TICK: begin
                busy_now = slot.busy;
            end
            MODE_PALETTE: begin
                accepted_now = idx_ok;
            end
            MODE_SET_ALL: begin
                accepted_now = 1'b1;
            end
            MODE_START: begin
                accepted_now = frame_idle;
                busy_now     = 1'b1;
            end
            default: begin
                accepted_now = 1'b0;
            end
        endcase
    end

    assign cmd.pal_we  = accept && (mode == MODE_PALETTE) && idx_ok;
    assign cmd.pal_idx = led_index;
    assign cmd.pal_rgb = palette(color_code);
    assign cmd.set_we  = accept && (mode == MODE_SET_ALL);
    assign cmd.set_rgb = {red, green, blue};
    assign cmd.set_n   = led_n;

    wps_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (accept && (mode == MODE_TICK)),
        .start   (accept && (mode == MODE_START)),
        .led_n   (led_n),
        .slot    (slot),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .idle    (frame_idle)
    );

    wps_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_rgb   (rd_rgb),
        .sweeping (sweeping)
    );

    // stage 1: waits on the ram read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && accept) begin
            st1_sel_reg  <= (mode == MODE_TICK) ? slot.sel : DUTY_ZERO;
            st1_bit_reg  <= slot.bit_pos;
            st1_busy_reg <= busy_now;
            st1_acc_reg  <= accepted_now;
        end
    end

    always_comb begin
        case (st1_sel_reg)
            DUTY_THIRD: begin
                duty_calc = third_reg;
            end
            DUTY_DATA: begin
                duty_calc = grb_bit(rd_rgb, st1_bit_reg) ? two_third_reg : third_reg;
            end
            default: begin
                duty_calc = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && st1_valid_reg) begin
            m_duty_reg <= duty_calc;
            m_busy_reg <= st1_busy_reg;
            m_acc_reg  <= st1_acc_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_acc_reg, m_busy_reg, m_busy_reg, m_duty_reg};

    `WPS_ASSERT_NEXT(a_st1_holds, st1_valid_reg && !out_load,
        st1_valid_reg && $stable(st1_sel_reg) && $stable(st1_bit_reg))
    `WPS_ASSERT_NEXT(a_st1_data_holds, st1_valid_reg && !out_load && (st1_sel_reg == DUTY_DATA),
        $stable(rd_rgb))

endmodule
